// ===== rtl/sensor_two_point_calibration_unit_macros.svh =====
// assertion helpers shared by the checker
`ifndef SENSOR_TWO_POINT_CALIBRATION_UNIT_MACROS_SVH
`define SENSOR_TWO_POINT_CALIBRATION_UNIT_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define STPC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define STPC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/stpc_pkg.sv =====
`default_nettype none

package stpc_pkg;

    // result format
    localparam int FRACTION_BITS = 8;
    localparam int RESULT_WIDTH  = 24;

    // field widths
    localparam int RAW_W   = 16;
    localparam int TPT_W   = 10;
    localparam int HPT_W   = 8;
    localparam int PT_W    = TPT_W;
    localparam int DIFF_W  = RAW_W + 1;
    localparam int PDIFF_W = PT_W + 1;
    localparam int PROD_W  = DIFF_W + PDIFF_W;
    localparam int SUM_W   = PROD_W + 1;
    localparam int MAG_W   = SUM_W - 1;

    // point scales: eighths of a degree, halves of a percent
    localparam int TEMP_SCALE_LOG2 = 3;
    localparam int HUM_SCALE_LOG2  = 1;
    localparam int TEMP_SHIFT      = FRACTION_BITS - TEMP_SCALE_LOG2;
    localparam int HUM_SHIFT       = FRACTION_BITS - HUM_SCALE_LOG2;

    // divider geometry: one quotient bit per cell
    localparam int NUM_W = MAG_W + HUM_SHIFT;
    localparam int DIV_W = RAW_W;
    localparam int CMP_W = ((NUM_W > RESULT_WIDTH) ? NUM_W : RESULT_WIDTH) + 1;

    localparam logic [RESULT_WIDTH-1:0] SAT_POS = {1'b0, {(RESULT_WIDTH-1){1'b1}}};
    localparam logic [RESULT_WIDTH-1:0] SAT_NEG = {1'b1, {(RESULT_WIDTH-1){1'b0}}};

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TEMP_P0 = 3'd0,
        REG_TEMP_P1 = 3'd1,
        REG_TEMP_R0 = 3'd2,
        REG_TEMP_R1 = 3'd3,
        REG_HUM_P0  = 3'd4,
        REG_HUM_P1  = 3'd5,
        REG_HUM_R0  = 3'd6,
        REG_HUM_R1  = 3'd7
    } cfg_reg_e;

    localparam logic CHAN_TEMP = 1'b0;
    localparam logic CHAN_HUM  = 1'b1;

    typedef struct packed {
        logic        [TPT_W-1:0] temp_p0;
        logic        [TPT_W-1:0] temp_p1;
        logic signed [RAW_W-1:0] temp_r0;
        logic signed [RAW_W-1:0] temp_r1;
        logic        [HPT_W-1:0] hum_p0;
        logic        [HPT_W-1:0] hum_p1;
        logic signed [RAW_W-1:0] hum_r0;
        logic signed [RAW_W-1:0] hum_r1;
    } cal_cfg_t;

    typedef struct packed {
        logic chan;
        logic neg;
        logic err;
    } div_meta_t;

    // link between neighboring divider cells
    typedef struct packed {
        logic             valid;
        div_meta_t        meta;
        logic [DIV_W-1:0] rem;
        logic [NUM_W-1:0] nq;
        logic [DIV_W-1:0] dvs;
    } div_stage_t;

    typedef struct packed {
        logic                    chan;
        logic [RESULT_WIDTH-1:0] value;
        logic                    sat;
        logic                    err;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/stpc_front.sv =====
`default_nettype none

module stpc_front
    import stpc_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    adv,
    input  wire logic                    in_valid,
    input  wire logic                    in_chan,
    input  wire logic signed [RAW_W-1:0] in_raw,
    input  wire cal_cfg_t                cfg,
    output div_stage_t                   div_entry
);

    // stage 1: pick the channel's points, form differences
    logic                      s1_valid_reg, s1_chan_reg;
    logic signed [DIFF_W-1:0]  s1_dr_reg, s1_dx_reg;
    logic signed [PDIFF_W-1:0] s1_dp_reg;
    logic        [PT_W-1:0]    s1_p0_reg;

    logic        [PT_W-1:0]    sel_p0, sel_p1;
    logic signed [RAW_W-1:0]   sel_r0, sel_r1;
    logic signed [DIFF_W-1:0]  s1_dr_next, s1_dx_next;
    logic signed [PDIFF_W-1:0] s1_dp_next;

    always_comb begin
        if (in_chan == CHAN_HUM) begin
            sel_p0 = PT_W'(cfg.hum_p0);
            sel_p1 = PT_W'(cfg.hum_p1);
            sel_r0 = cfg.hum_r0;
            sel_r1 = cfg.hum_r1;
        end else begin
            sel_p0 = cfg.temp_p0;
            sel_p1 = cfg.temp_p1;
            sel_r0 = cfg.temp_r0;
            sel_r1 = cfg.temp_r1;
        end
        s1_dr_next = $signed({sel_r1[RAW_W-1], sel_r1}) - $signed({sel_r0[RAW_W-1], sel_r0});
        s1_dx_next = $signed({in_raw[RAW_W-1], in_raw}) - $signed({sel_r0[RAW_W-1], sel_r0});
        s1_dp_next = $signed({1'b0, sel_p1}) - $signed({1'b0, sel_p0});
    end

    // stage 2: the two products, divisor magnitude
    logic                     s2_valid_reg, s2_chan_reg, s2_err_reg, s2_drneg_reg;
    logic        [DIV_W-1:0]  s2_dvs_reg;
    logic signed [PROD_W-1:0] s2_pa_reg, s2_pb_reg;
    logic signed [PROD_W-1:0] s2_pa_next, s2_pb_next;
    logic        [DIFF_W-1:0] s2_dr_abs;

    assign s2_pa_next = $signed({1'b0, s1_p0_reg}) * s1_dr_reg;
    assign s2_pb_next = s1_dx_reg * s1_dp_reg;
    assign s2_dr_abs  = s1_dr_reg[DIFF_W-1] ? (~s1_dr_reg + 1'b1) : s1_dr_reg;

    // stage 3: interpolation numerator
    logic                    s3_valid_reg, s3_chan_reg, s3_err_reg, s3_drneg_reg;
    logic       [DIV_W-1:0]  s3_dvs_reg;
    logic signed [SUM_W-1:0] s3_sum_reg, s3_sum_next;

    assign s3_sum_next = $signed({s2_pa_reg[PROD_W-1], s2_pa_reg})
                       + $signed({s2_pb_reg[PROD_W-1], s2_pb_reg});

    // stage 4: sign and magnitude, aligned for the point scale
    div_stage_t       entry_reg, entry_next;
    logic [SUM_W-1:0] sum_abs;
    logic [NUM_W-1:0] mag_ext;

    always_comb begin
        sum_abs = s3_sum_reg[SUM_W-1] ? (~s3_sum_reg + 1'b1) : s3_sum_reg;
        mag_ext = {{HUM_SHIFT{1'b0}}, sum_abs[MAG_W-1:0]};
        entry_next.valid    = s3_valid_reg;
        entry_next.meta     = '{chan: s3_chan_reg,
                                neg:  s3_sum_reg[SUM_W-1] ^ s3_drneg_reg,
                                err:  s3_err_reg};
        entry_next.rem      = '0;
        entry_next.nq       = (s3_chan_reg == CHAN_HUM) ? (mag_ext << HUM_SHIFT)
                                                        : (mag_ext << TEMP_SHIFT);
        entry_next.dvs      = s3_dvs_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg    <= 1'b0;
            s2_valid_reg    <= 1'b0;
            s3_valid_reg    <= 1'b0;
            entry_reg.valid <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= in_valid;
            s1_chan_reg  <= in_chan;
            s1_dr_reg    <= s1_dr_next;
            s1_dx_reg    <= s1_dx_next;
            s1_dp_reg    <= s1_dp_next;
            s1_p0_reg    <= sel_p0;

            s2_valid_reg <= s1_valid_reg;
            s2_chan_reg  <= s1_chan_reg;
            s2_err_reg   <= (s1_dr_reg == '0);
            s2_drneg_reg <= s1_dr_reg[DIFF_W-1];
            s2_dvs_reg   <= s2_dr_abs[DIV_W-1:0];
            s2_pa_reg    <= s2_pa_next;
            s2_pb_reg    <= s2_pb_next;

            s3_valid_reg <= s2_valid_reg;
            s3_chan_reg  <= s2_chan_reg;
            s3_err_reg   <= s2_err_reg;
            s3_drneg_reg <= s2_drneg_reg;
            s3_dvs_reg   <= s2_dvs_reg;
            s3_sum_reg   <= s3_sum_next;

            entry_reg    <= entry_next;
        end
    end

    assign div_entry = entry_reg;

endmodule

`default_nettype wire

// ===== rtl/stpc_div_cell.sv =====
`default_nettype none

module stpc_div_cell
    import stpc_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       adv,
    input  wire div_stage_t stage_in,
    output div_stage_t      stage_out
);

    // one restoring step: shift in the next numerator bit, try the divisor
    div_stage_t       stage_reg, stage_next;
    logic [DIV_W:0]   rem_sh, rem_sub;
    logic             ge;

    always_comb begin
        rem_sh  = {stage_in.rem, stage_in.nq[NUM_W-1]};
        rem_sub = rem_sh - {1'b0, stage_in.dvs};
        ge      = (rem_sh >= {1'b0, stage_in.dvs});
        stage_next       = stage_in;
        stage_next.rem   = ge ? rem_sub[DIV_W-1:0] : rem_sh[DIV_W-1:0];
        stage_next.nq    = {stage_in.nq[NUM_W-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg.valid <= 1'b0;
        end else if (adv) begin
            stage_reg <= stage_next;
        end
    end

    assign stage_out = stage_reg;

endmodule

`default_nettype wire

// ===== rtl/stpc_back.sv =====
`default_nettype none

module stpc_back
    import stpc_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire div_stage_t div_last,
    input  wire logic       m_ready,
    output logic            adv,
    output logic            out_valid,
    output result_t         out_data
);

    localparam logic [CMP_W-1:0] POS_LIM =
        {{(CMP_W-RESULT_WIDTH+1){1'b0}}, {(RESULT_WIDTH-1){1'b1}}};
    localparam logic [CMP_W-1:0] NEG_LIM = POS_LIM + 1'b1;

    logic             out_valid_reg, out_valid_next;
    logic             skid_valid_reg, skid_valid_next;
    result_t          out_reg, out_next, skid_reg, skid_next;
    result_t          res;
    logic             in_v;
    logic [CMP_W-1:0] qx, val_ext;
    logic             over;

    // sign, saturation and calibration error
    always_comb begin
        qx      = {{(CMP_W-NUM_W){1'b0}}, div_last.nq};
        over    = div_last.meta.neg ? (qx > NEG_LIM) : (qx > POS_LIM);
        val_ext = div_last.meta.neg ? (~qx + 1'b1) : qx;
        res.chan = div_last.meta.chan;
        res.err  = div_last.meta.err;
        if (div_last.meta.err) begin
            res.value = '0;
            res.sat   = 1'b0;
        end else if (over) begin
            res.value = div_last.meta.neg ? SAT_NEG : SAT_POS;
            res.sat   = 1'b1;
        end else begin
            res.value = val_ext[RESULT_WIDTH-1:0];
            res.sat   = 1'b0;
        end
    end

    assign adv  = !skid_valid_reg;
    assign in_v = div_last.valid && adv;

    // output register with one skid entry behind it
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (!out_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = in_v;
                if (in_v) begin
                    out_next = res;
                end
            end
        end else if (in_v) begin
            skid_valid_next = 1'b1;
            skid_next       = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
            out_reg        <= out_next;
            skid_reg       <= skid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

`default_nettype wire

// ===== rtl/sensor_two_point_calibration_unit.sv =====
// two-point linear calibration of raw temperature and humidity samples
// input channel s_*: one item carries a channel tag (0 temperature, 1 humidity)
//   and a raw signed 16-bit sample; taken when s_valid and s_ready are high
// result channel m_*: channel echo, value in units times 256 (truncated toward
//   zero, clipped to 24 bits), saturation flag and calibration error flag
// configuration channel cfg_*: cfg_index picks one of eight point registers,
//   cfg_data is written on cfg_valid; cfg_ready is always high
// pipeline: four front stages (select, multiply, sum, magnitude), one
//   divider cell per quotient bit (35 cells) and the output register
// throughput: one item per cycle while the pipeline is not held, bounded by
//   the divider cell row, which accepts a new dividend each cycle it advances
// reset: all point registers go to zero, pipeline and output empty, s_ready high
// stall: a result waiting at m_* does not block the input right away; one more
//   item lands in a skid entry, then the whole pipeline holds until m_ready
// equal raw points for a channel give cal_error with a zero value
`default_nettype none

module sensor_two_point_calibration_unit
    import stpc_pkg::*;
(
    input  wire logic                           aclk,
    input  wire logic                           aresetn,

    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic                           s_command,
    input  wire logic signed [RAW_W-1:0]        s_raw_sample,

    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic                                m_channel,
    output logic signed [RESULT_WIDTH-1:0]      m_calibrated_value,
    output logic                                m_saturated,
    output logic                                m_cal_error,

    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]           cfg_index,
    input  wire logic [CFG_DATA_W-1:0]          cfg_data
);

    // calibration point registers
    cal_cfg_t cfg_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_reg_e'(cfg_index))
                REG_TEMP_P0: cfg_reg.temp_p0 <= cfg_data[TPT_W-1:0];
                REG_TEMP_P1: cfg_reg.temp_p1 <= cfg_data[TPT_W-1:0];
                REG_TEMP_R0: cfg_reg.temp_r0 <= cfg_data[RAW_W-1:0];
                REG_TEMP_R1: cfg_reg.temp_r1 <= cfg_data[RAW_W-1:0];
                REG_HUM_P0:  cfg_reg.hum_p0  <= cfg_data[HPT_W-1:0];
                REG_HUM_P1:  cfg_reg.hum_p1  <= cfg_data[HPT_W-1:0];
                REG_HUM_R0:  cfg_reg.hum_r0  <= cfg_data[RAW_W-1:0];
                REG_HUM_R1:  cfg_reg.hum_r1  <= cfg_data[RAW_W-1:0];
            endcase
        end
    end

    // whole pipeline steps together; holds only while the skid entry is full
    logic       adv;
    div_stage_t div_link [NUM_W+1];
    result_t    out_data;

    assign s_ready = adv;

    // selection, multiplies and numerator forming
    stpc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (s_valid),
        .in_chan   (s_command),
        .in_raw    (s_raw_sample),
        .cfg       (cfg_reg),
        .div_entry (div_link[0])
    );

    // row of divider cells, msb of the quotient first
    for (genvar gi = 0; gi < NUM_W; gi++) begin : g_div
        stpc_div_cell u_div_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .adv       (adv),
            .stage_in  (div_link[gi]),
            .stage_out (div_link[gi+1])
        );
    end

    // sign, clipping and the output register with its skid entry
    stpc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .div_last  (div_link[NUM_W]),
        .m_ready   (m_ready),
        .adv       (adv),
        .out_valid (m_valid),
        .out_data  (out_data)
    );

    assign m_channel          = out_data.chan;
    assign m_calibrated_value = out_data.value;
    assign m_saturated        = out_data.sat;
    assign m_cal_error        = out_data.err;

endmodule

`default_nettype wire

// ===== rtl/stpc_checker.sv =====
`default_nettype none

`include "sensor_two_point_calibration_unit_macros.svh"

module stpc_checker
    import stpc_pkg::*;
(
    input wire logic                      aclk,
    input wire logic                      aresetn,
    input wire logic                      s_ready,
    input wire logic                      m_valid,
    input wire logic                      m_ready,
    input wire logic                      m_channel,
    input wire logic signed [RESULT_WIDTH-1:0] m_calibrated_value,
    input wire logic                      m_saturated,
    input wire logic                      m_cal_error
);

    // a stalled result keeps its payload
    `STPC_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_channel) && $stable(m_calibrated_value) && $stable(m_saturated) && $stable(m_cal_error), "stalled result changed")

    // calibration error forces a clean zero
    `STPC_ASSERT_SAME(a_err_zero, m_valid && m_cal_error, m_calibrated_value == '0 && !m_saturated, "error item not zero")

    // clipped values sit on a rail
    `STPC_ASSERT_SAME(a_sat_rail, m_valid && m_saturated, m_calibrated_value == SAT_POS || m_calibrated_value == SAT_NEG, "saturated value off rail")

    // leaving reset: no result shown, input open
    `STPC_ASSERT_SAME(a_reset_idle, $past(!aresetn), !m_valid && s_ready, "not idle after reset")

endmodule

bind sensor_two_point_calibration_unit stpc_checker u_stpc_checker (.*);

`default_nettype wire
